// ----- design/llim_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package llim_pkg;

	localparam int VALUE_WIDTH      = 32;
	localparam int TIME_WIDTH       = 32;
	localparam int TRIP_COUNT_WIDTH = 16;
	localparam int CFG_DATA_WIDTH   = 32;
	localparam int CFG_INDEX_WIDTH  = 3;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_CONDITION_MODE = 3'd0,
		REG_LOW_THRESHOLD  = 3'd1,
		REG_HIGH_THRESHOLD = 3'd2,
		REG_DEBOUNCE_US    = 3'd3,
		REG_REQUIRE_FRESH  = 3'd4,
		REG_ACTION_MODE    = 3'd5,
		REG_LIMIT_ENABLED  = 3'd6
	} reg_index_t;

	typedef enum logic [1:0] {
		COND_ABOVE   = 2'd0,
		COND_BELOW   = 2'd1,
		COND_OUTSIDE = 2'd2
	} cond_mode_t;

	typedef enum logic [1:0] {
		ACT_TRIP_ALL = 2'd0,
		ACT_RELEASE  = 2'd1,
		ACT_ALARM    = 2'd2
	} act_mode_t;

	typedef enum logic [1:0] {
		QUAL_GOOD      = 2'd0,
		QUAL_RANGE     = 2'd1,
		QUAL_UNTRUSTED = 2'd2,
		QUAL_MISSING   = 2'd3
	} quality_t;

	typedef enum logic [1:0] {
		REASON_NONE      = 2'd0,
		REASON_MISSING   = 2'd1,
		REASON_UNTRUSTED = 2'd2,
		REASON_EXCEEDED  = 2'd3
	} reason_t;

	localparam logic OP_EVALUATE = 1'b0;
	localparam logic OP_RESET    = 1'b1;

	localparam logic [2:0] SEV_NONE     = 3'd0;
	localparam logic [2:0] SEV_OTHER    = 3'd3;
	localparam logic [2:0] SEV_TRIP_ALL = 3'd4;

	typedef struct packed {
		logic                          operation;
		logic signed [VALUE_WIDTH-1:0] sample_value;
		logic [1:0]                    sample_quality;
		logic [TIME_WIDTH-1:0]         now_us;
		logic                          outputs_tripped;
	} in_item_t;

	typedef struct packed {
		logic                        limit_latched;
		logic                        violation_seen;
		logic                        action_fired;
		logic [1:0]                  action_taken;
		logic [2:0]                  severity;
		logic                        reassert_trip;
		logic [1:0]                  reason_code;
		logic [TRIP_COUNT_WIDTH-1:0] trip_count;
	} out_item_t;

endpackage

`default_nettype wire

// ----- design/latching_limit_interlock_unit.sv -----
// The input register holds accepted beats, the result register their results.
// One beat per cycle unless the output stalls; the input register feeds
// the result register via the threshold compares and one timestamp subtraction.
// Reset clears the latch, tracking, trip counter and configuration
// (require_fresh comes up set, all else zero); no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module latching_limit_interlock_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire llim_pkg::in_item_t              in_data,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output llim_pkg::out_item_t                  out_data,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire [llim_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  wire [llim_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
	import llim_pkg::*;

	logic [1:0]                    cond_mode_q;
	logic signed [VALUE_WIDTH-1:0] low_thr_q;
	logic signed [VALUE_WIDTH-1:0] high_thr_q;
	logic [TIME_WIDTH-1:0]         debounce_q;
	logic                          require_fresh_q;
	logic [1:0]                    action_mode_q;
	logic                          enabled_q;

	logic                        latched_q;
	logic                        violating_q;
	logic [TIME_WIDTH-1:0]       start_q;
	logic [TRIP_COUNT_WIDTH-1:0] trips_q;
	logic [1:0]                  reason_q;

	in_item_t item_s1;
	logic     valid_s1;
	logic     out_free;
	logic     advance;

	logic                        latched_d;
	logic                        violating_d;
	logic [TIME_WIDTH-1:0]       start_d;
	logic [TRIP_COUNT_WIDTH-1:0] trips_d;
	logic [1:0]                  reason_d;
	logic                        fired;
	logic [1:0]                  taken;
	logic [2:0]                  sev;
	logic                        reassert;
	logic                        viol;
	logic [1:0]                  reason_now;
	logic [TIME_WIDTH-1:0]       start_eff;
	logic [TIME_WIDTH-1:0]       elapsed;
	logic                        wait_more;
	logic [1:0]                  mode_eff;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cond_mode_q     <= COND_ABOVE;
			low_thr_q       <= '0;
			high_thr_q      <= '0;
			debounce_q      <= '0;
			require_fresh_q <= 1'b1;
			action_mode_q   <= ACT_TRIP_ALL;
			enabled_q       <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CONDITION_MODE: cond_mode_q     <= cfg_data[1:0];
				REG_LOW_THRESHOLD:  low_thr_q       <= cfg_data[VALUE_WIDTH-1:0];
				REG_HIGH_THRESHOLD: high_thr_q      <= cfg_data[VALUE_WIDTH-1:0];
				REG_DEBOUNCE_US:    debounce_q      <= cfg_data[TIME_WIDTH-1:0];
				REG_REQUIRE_FRESH:  require_fresh_q <= cfg_data[0];
				REG_ACTION_MODE:    action_mode_q   <= cfg_data[1:0];
				REG_LIMIT_ENABLED:  enabled_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_comb begin
		viol       = 1'b0;
		reason_now = REASON_NONE;
		case (item_s1.sample_quality)
			QUAL_MISSING: begin
				viol       = require_fresh_q;
				reason_now = REASON_MISSING;
			end
			QUAL_UNTRUSTED: begin
				viol       = require_fresh_q;
				reason_now = REASON_UNTRUSTED;
			end
			default: begin
				case (cond_mode_q)
					COND_ABOVE:   viol = item_s1.sample_value > high_thr_q;
					COND_BELOW:   viol = item_s1.sample_value < low_thr_q;
					COND_OUTSIDE: viol = (item_s1.sample_value < low_thr_q) ||
						(item_s1.sample_value > high_thr_q);
					default:      viol = 1'b0;
				endcase
				reason_now = viol ? REASON_EXCEEDED : REASON_NONE;
			end
		endcase

		start_eff = violating_q ? start_q : item_s1.now_us;
		elapsed   = item_s1.now_us - start_eff;
		wait_more = (debounce_q != '0) && (item_s1.now_us >= start_eff) &&
			(elapsed < debounce_q);
		mode_eff  = ((action_mode_q == ACT_TRIP_ALL) || (action_mode_q == ACT_RELEASE)) ?
			action_mode_q : ACT_ALARM;
	end

	always_comb begin
		latched_d   = latched_q;
		violating_d = violating_q;
		start_d     = start_q;
		trips_d     = trips_q;
		reason_d    = reason_q;
		fired       = 1'b0;
		taken       = ACT_TRIP_ALL;
		sev         = SEV_NONE;
		reassert    = 1'b0;
		if (item_s1.operation == OP_RESET) begin
			latched_d   = 1'b0;
			violating_d = 1'b0;
			start_d     = '0;
			reason_d    = REASON_NONE;
		end else if (!enabled_q) begin
			latched_d = latched_q;
		end else if (latched_q) begin
			reassert = (action_mode_q == ACT_TRIP_ALL) && !item_s1.outputs_tripped;
		end else if (!viol) begin
			violating_d = 1'b0;
			start_d     = '0;
		end else begin
			violating_d = 1'b1;
			start_d     = start_eff;
			if (!wait_more) begin
				latched_d = 1'b1;
				if (trips_q != '1) begin
					trips_d = trips_q + 1'b1;
				end
				reason_d = reason_now;
				fired    = 1'b1;
				taken    = mode_eff;
				sev      = (mode_eff == ACT_TRIP_ALL) ? SEV_TRIP_ALL : SEV_OTHER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q   <= 1'b0;
			violating_q <= 1'b0;
			start_q     <= '0;
			trips_q     <= '0;
			reason_q    <= REASON_NONE;
			out_valid   <= 1'b0;
		end else begin
			if (advance) begin
				latched_q   <= latched_d;
				violating_q <= violating_d;
				start_q     <= start_d;
				trips_q     <= trips_d;
				reason_q    <= reason_d;
			end
			if (out_free) begin
				out_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data.limit_latched  <= latched_d;
			out_data.violation_seen <= violating_d;
			out_data.action_fired   <= fired;
			out_data.action_taken   <= taken;
			out_data.severity       <= sev;
			out_data.reassert_trip  <= reassert;
			out_data.reason_code    <= reason_d;
			out_data.trip_count     <= trips_d;
		end
	end

endmodule

`default_nettype wire
